FILE: hdl/square_channel_duty_envelope_length_top_assert.svh
// Assertion macros used by the checker file of the square channel.
`ifndef SQUARE_CHANNEL_DUTY_ENVELOPE_LENGTH_TOP_ASSERT_SVH
`define SQUARE_CHANNEL_DUTY_ENVELOPE_LENGTH_TOP_ASSERT_SVH

`define SQCH_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("square channel check failed");

`define SQCH_ASSERT_NXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("square channel check failed");

`endif

FILE: hdl/sqch_pkg.sv
`default_nettype none

package sqch_pkg;

    localparam logic [2:0] CMD_TICK     = 3'd0;
    localparam logic [2:0] CMD_LENGTH   = 3'd1;
    localparam logic [2:0] CMD_ENVELOPE = 3'd2;
    localparam logic [2:0] CMD_WR_DUTY  = 3'd3;
    localparam logic [2:0] CMD_WR_ENV   = 3'd4;
    localparam logic [2:0] CMD_WR_CTRL  = 3'd5;

    localparam int unsigned NumWaves = 4;

    localparam logic [7:0] WAVE_RESET [NumWaves] = '{8'h01, 8'h81, 8'h87, 8'h7E};

    typedef struct packed {
        logic [2:0] command;
        logic [7:0] tick_cycles;
        logic [7:0] data_byte;
        logic [7:0] period_low;
    } t_in_word;

    typedef struct packed {
        logic signed [4:0] level;
        logic              channel_active;
    } t_out_word;

    typedef struct packed {
        logic        start;
        logic        trigger;
        logic [7:0]  cycles;
        logic [10:0] period;
    } t_tmr_ctl;

endpackage

`default_nettype wire

FILE: hdl/sqch_timer.sv
`default_nettype none

module sqch_timer import sqch_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  t_tmr_ctl   i_ctl,
    output logic       o_busy,
    output logic [2:0] o_duty_step
);

    logic [13:0]        r_timer;
    logic signed [14:0] r_t;
    logic               r_busy;
    logic [2:0]         r_step;

    logic [11:0]        w_dist;
    logic [13:0]        w_reload;
    logic signed [14:0] w_opa;
    logic signed [14:0] w_opb;
    logic signed [14:0] w_sum;

    // The one adder first subtracts the elapsed cycles, then adds one reload per cycle.
    assign w_dist   = 12'd2048 - {1'b0, i_ctl.period};
    assign w_reload = {w_dist, 2'b00};
    assign w_opa    = r_busy ? r_t : $signed({1'b0, r_timer});
    assign w_opb    = r_busy ? $signed({1'b0, w_reload}) : -$signed({7'b0, i_ctl.cycles});
    assign w_sum    = w_opa + w_opb;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_timer <= '0;
            r_busy  <= 1'b0;
            r_step  <= '0;
        end else begin
            if (i_ctl.trigger) begin
                r_timer <= w_reload;
            end
            if (i_ctl.start) begin
                r_t    <= w_sum;
                r_busy <= 1'b1;
            end else if (r_busy) begin
                if (r_t <= 15'sd0) begin
                    r_t    <= w_sum;
                    r_step <= r_step + 3'd1;
                end else begin
                    r_timer <= r_t[13:0];
                    r_busy  <= 1'b0;
                end
            end
        end
    end

    assign o_busy      = r_busy;
    assign o_duty_step = r_step;

endmodule

`default_nettype wire

FILE: hdl/square_channel_duty_envelope_length_top.sv
`default_nettype none

// Square-wave sound channel. Every accepted word (a timer tick, a length or envelope
// clock, or a register write) yields one result word with the output level in
// fifteenths and the channel-on flag. Words other than a tick pass through S_FINISH
// on their way to the result register. A tick stays in S_TICK while the period timer
// makes the 0 to 64 reloads that it causes: the timer has a single adder that
// adds one reload value per cycle. The input is stalled while a word is in work and
// while an unaccepted result is held. Duty pattern registers may be written at any
// time the block is idle; the configuration port is always ready.
module square_channel_duty_envelope_length_top import sqch_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    output logic       o_in_stall,
    input  t_in_word   i_in_word,
    output logic       o_out_valid,
    input  logic       i_out_stall,
    output t_out_word  o_out_word,
    input  logic       i_cfg_valid,
    output logic       o_cfg_ready,
    input  logic [2:0] i_cfg_index,
    input  logic [7:0] i_cfg_data
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_TICK,
        S_FINISH
    } t_state;

    t_state      r_state;
    logic [7:0]  r_wave [NumWaves];
    logic        r_channel_on;
    logic        r_dac_enabled;
    logic [10:0] r_period;
    logic [1:0]  r_duty_sel;
    logic [6:0]  r_len;
    logic        r_len_active;
    logic [3:0]  r_volume;
    logic [3:0]  r_env_init;
    logic        r_env_up;
    logic [2:0]  r_env_period;
    logic [7:0]  r_env_count;
    logic        r_out_valid;
    t_out_word   r_out_word;

    logic        w_accept;
    logic        w_trigger;
    logic [10:0] w_new_period;
    logic [7:0]  w_env_next;
    logic        w_tmr_busy;
    logic [2:0]  w_duty_step;
    logic        w_duty_bit;
    logic signed [5:0] w_level;
    t_tmr_ctl    w_tmr_ctl;
    t_out_word   w_result;

    assign o_in_stall   = (r_state != S_IDLE) || (r_out_valid && i_out_stall);
    assign w_accept     = i_in_valid && !o_in_stall;
    assign w_trigger    = w_accept && (i_in_word.command == CMD_WR_CTRL)
                          && i_in_word.data_byte[7];
    assign w_new_period = {i_in_word.data_byte[2:0], i_in_word.period_low};
    assign w_env_next   = r_env_count - 8'd1;

    always_comb begin
        w_tmr_ctl.start   = w_accept && (i_in_word.command == CMD_TICK);
        w_tmr_ctl.trigger = w_trigger;
        w_tmr_ctl.cycles  = i_in_word.tick_cycles;
        w_tmr_ctl.period  = w_trigger ? w_new_period : r_period;
    end

    sqch_timer u_timer (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_ctl       (w_tmr_ctl),
        .o_busy      (w_tmr_busy),
        .o_duty_step (w_duty_step)
    );

    assign w_level = $signed({1'b0, (w_duty_bit ? r_volume : 4'd0), 1'b0}) - 6'sd15;

    always_comb begin
        w_duty_bit              = r_wave[r_duty_sel][w_duty_step];
        w_result.channel_active = r_channel_on;
        if (r_channel_on && r_dac_enabled) begin
            w_result.level = w_level[4:0];
        end else begin
            w_result.level = 5'sd0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= S_IDLE;
            for (int i = 0; i < NumWaves; i++) begin
                r_wave[i] <= WAVE_RESET[i];
            end
            r_channel_on  <= 1'b0;
            r_dac_enabled <= 1'b0;
            r_period      <= '0;
            r_duty_sel    <= '0;
            r_len         <= '0;
            r_len_active  <= 1'b0;
            r_volume      <= '0;
            r_env_init    <= '0;
            r_env_up      <= 1'b0;
            r_env_period  <= '0;
            r_env_count   <= '0;
            r_out_valid   <= 1'b0;
        end else begin
            if (i_cfg_valid && o_cfg_ready && (i_cfg_index < 3'(NumWaves))) begin
                r_wave[i_cfg_index[1:0]] <= i_cfg_data;
            end

            if (r_out_valid && !i_out_stall) begin
                r_out_valid <= 1'b0;
            end

            case (r_state)
                S_IDLE: begin
                    if (w_accept) begin
                        r_state <= (i_in_word.command == CMD_TICK) ? S_TICK : S_FINISH;
                        case (i_in_word.command)
                            CMD_LENGTH: begin
                                if (r_len_active && (r_len != 7'd0)) begin
                                    r_len <= r_len - 7'd1;
                                    if (r_len == 7'd1) begin
                                        r_channel_on <= 1'b0;
                                    end
                                end
                            end
                            CMD_ENVELOPE: begin
                                if (r_env_period != 3'd0) begin
                                    if (w_env_next == 8'd0) begin
                                        r_env_count <= {5'd0, r_env_period};
                                        if (r_env_up) begin
                                            if (r_volume != 4'd15) begin
                                                r_volume <= r_volume + 4'd1;
                                            end
                                        end else if (r_volume != 4'd0) begin
                                            r_volume <= r_volume - 4'd1;
                                        end
                                    end else begin
                                        r_env_count <= w_env_next;
                                    end
                                end
                            end
                            CMD_WR_DUTY: begin
                                r_duty_sel <= i_in_word.data_byte[7:6];
                                r_len      <= 7'd64 - {1'b0, i_in_word.data_byte[5:0]};
                            end
                            CMD_WR_ENV: begin
                                r_dac_enabled <= (i_in_word.data_byte[7:3] != 5'd0);
                                if (i_in_word.data_byte[7:3] == 5'd0) begin
                                    r_channel_on <= 1'b0;
                                end
                                r_env_init   <= i_in_word.data_byte[7:4];
                                r_env_up     <= i_in_word.data_byte[3];
                                r_env_period <= i_in_word.data_byte[2:0];
                            end
                            CMD_WR_CTRL: begin
                                r_len_active <= i_in_word.data_byte[6];
                                if (i_in_word.data_byte[7]) begin
                                    r_period <= w_new_period;
                                    if (r_len == 7'd0) begin
                                        r_len <= 7'd64;
                                    end
                                    r_volume      <= r_env_init;
                                    r_env_count   <= {5'd0, r_env_period};
                                    r_dac_enabled <= ({r_env_init, r_env_up} != 5'd0);
                                    r_channel_on  <= ({r_env_init, r_env_up} != 5'd0);
                                end
                            end
                            default: begin
                            end
                        endcase
                    end
                end
                S_TICK: begin
                    if (!w_tmr_busy) begin
                        r_out_valid <= 1'b1;
                        r_out_word  <= w_result;
                        r_state     <= S_IDLE;
                    end
                end
                S_FINISH: begin
                    r_out_valid <= 1'b1;
                    r_out_word  <= w_result;
                    r_state     <= S_IDLE;
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_cfg_ready = 1'b1;
    assign o_out_valid = r_out_valid;
    assign o_out_word  = r_out_word;

endmodule

`default_nettype wire

FILE: hdl/sqch_checker.sv
`default_nettype none

`include "square_channel_duty_envelope_length_top_assert.svh"

module sqch_checker import sqch_pkg::*; (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       i_in_valid,
    input logic       o_in_stall,
    input logic       o_out_valid,
    input logic       i_out_stall,
    input t_out_word  o_out_word
);

    `SQCH_ASSERT_NXT(a_out_hold, o_out_valid && i_out_stall, o_out_valid && $stable(o_out_word))
    `SQCH_ASSERT_NXT(a_busy_after_accept, i_in_valid && !o_in_stall, o_in_stall)
    `SQCH_ASSERT_IMP(a_off_is_silent, o_out_valid && !o_out_word.channel_active, o_out_word.level == 5'sd0)
    `SQCH_ASSERT_IMP(a_level_odd, o_out_valid && (o_out_word.level != 5'sd0), o_out_word.level[0])

endmodule

bind square_channel_duty_envelope_length_top sqch_checker u_checker (.*);

`default_nettype wire
